FILE: hw/rtl/clipped_window_histogram_smoother_top_defines.svh
// assertion macros for the histogram smoother
`ifndef CLIPPED_WINDOW_HISTOGRAM_SMOOTHER_TOP_DEFINES_SVH
`define CLIPPED_WINDOW_HISTOGRAM_SMOOTHER_TOP_DEFINES_SVH

`ifndef SYNTH
`define CWHS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define CWHS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define CWHS_ASSERT(lbl, prop, msg)
`define CWHS_ASSERT_RST(lbl, prop, msg)
`endif

`endif

FILE: hw/rtl/cwhs_pkg.sv
package cwhs_pkg;

  localparam int DEPTH      = 64;
  localparam int COUNT_BITS = 32;
  localparam int FRAC_BITS  = 8;
  localparam int IDX_BITS   = $clog2(DEPTH);
  localparam int CNT_BITS   = IDX_BITS + 1;
  localparam int CFG_BITS   = 6;
  localparam int ADDR_BITS  = 2;
  localparam int OUT_BITS   = COUNT_BITS + FRAC_BITS;
  localparam int SUM_BITS   = COUNT_BITS + IDX_BITS;
  localparam int DIVD_BITS  = SUM_BITS + FRAC_BITS;
  localparam int LEN_BITS   = IDX_BITS + 1;
  localparam int STEP_BITS  = $clog2(DIVD_BITS);

  typedef enum logic [ADDR_BITS-1:0] {
    REG_RADIUS_LEFT  = 2'd0,
    REG_RADIUS_RIGHT = 2'd1,
    REG_RANGE_START  = 2'd2,
    REG_RANGE_END    = 2'd3
  } cwhs_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SUM,
    ST_SUM_TAIL,
    ST_DIV_LOAD,
    ST_DIV,
    ST_MEAN_OUT,
    ST_RAW_RD,
    ST_RAW_OUT,
    ST_OUT
  } cwhs_state_e;

  typedef struct packed {
    logic [COUNT_BITS-1:0] bin_value;
    logic                  last_bin;
  } cwhs_in_t;

  typedef struct packed {
    logic [IDX_BITS-1:0] bin_index;
    logic [OUT_BITS-1:0] smoothed_value;
    logic                last_result;
  } cwhs_out_t;

  typedef struct packed {
    logic load;
    logic start;
    logic setup;
    logic sum_rd;
    logic raw_rd;
    logic div_load;
    logic div_step;
    logic out_mean;
    logic out_raw;
    logic next_bin;
    logic pass_done;
  } cwhs_cmd_t;

  typedef struct packed {
    logic in_range;
    logic at_hi;
    logic div_done;
    logic out_acc;
    logic out_last;
  } cwhs_stat_t;

endpackage

FILE: hw/rtl/cwhs_ctrl.sv
module cwhs_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_last_i,
  input  cwhs_pkg::cwhs_stat_t stat_i,
  output logic               in_ready_o,
  output cwhs_pkg::cwhs_cmd_t  cmd_o
);
  import cwhs_pkg::*;

  cwhs_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_last_i) begin
          state_d = ST_SETUP;
        end
      end
      ST_SETUP:    state_d = stat_i.in_range ? ST_SUM : ST_RAW_RD;
      ST_SUM: begin
        if (stat_i.at_hi) begin
          state_d = ST_SUM_TAIL;
        end
      end
      ST_SUM_TAIL: state_d = ST_DIV_LOAD;
      ST_DIV_LOAD: state_d = ST_DIV;
      ST_DIV: begin
        if (stat_i.div_done) begin
          state_d = ST_MEAN_OUT;
        end
      end
      ST_MEAN_OUT: state_d = ST_OUT;
      ST_RAW_RD:   state_d = ST_RAW_OUT;
      ST_RAW_OUT:  state_d = ST_OUT;
      ST_OUT: begin
        if (stat_i.out_acc) begin
          state_d = stat_i.out_last ? ST_IDLE : ST_SETUP;
        end
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.load  = in_valid_i;
        cmd_o.start = in_valid_i && in_last_i;
      end
      ST_SETUP:    cmd_o.setup    = 1'b1;
      ST_SUM:      cmd_o.sum_rd   = 1'b1;
      ST_DIV_LOAD: cmd_o.div_load = 1'b1;
      ST_DIV:      cmd_o.div_step = 1'b1;
      ST_MEAN_OUT: cmd_o.out_mean = 1'b1;
      ST_RAW_RD:   cmd_o.raw_rd   = 1'b1;
      ST_RAW_OUT:  cmd_o.out_raw  = 1'b1;
      ST_OUT: begin
        cmd_o.next_bin  = stat_i.out_acc && !stat_i.out_last;
        cmd_o.pass_done = stat_i.out_acc && stat_i.out_last;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

FILE: hw/rtl/cwhs_dp.sv
module cwhs_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  cwhs_pkg::cwhs_cmd_t                cmd_i,
  input  cwhs_pkg::cwhs_in_t                 in_data_i,
  input  logic                               cfg_we_i,
  input  logic [cwhs_pkg::ADDR_BITS-1:0]     cfg_addr_i,
  input  logic [cwhs_pkg::CFG_BITS-1:0]      cfg_data_i,
  input  logic                               out_ready_i,
  output cwhs_pkg::cwhs_stat_t               stat_o,
  output logic                               out_valid_o,
  output cwhs_pkg::cwhs_out_t                out_data_o
);
  import cwhs_pkg::*;

  logic [COUNT_BITS-1:0] mem_q [DEPTH];
  logic [COUNT_BITS-1:0] rdata_q;
  logic                  rd_vld_q;

  logic [CFG_BITS-1:0]   rl_q, rr_q, rs_q, re_q;
  logic [CNT_BITS-1:0]   cnt_q;
  logic [IDX_BITS-1:0]   idx_q, ptr_q, hi_q;
  logic [LEN_BITS-1:0]   len_q;
  logic [SUM_BITS-1:0]   acc_q;
  logic [LEN_BITS-1:0]   rem_q;
  logic [DIVD_BITS-1:0]  quo_q;
  logic [STEP_BITS-1:0]  step_q;
  logic                  out_valid_q;
  cwhs_out_t             out_q;

  logic [CNT_BITS-1:0]   n_m1;
  logic [IDX_BITS-1:0]   e_clip, lo, hi;
  logic [IDX_BITS:0]     lo_raw, hi_raw;
  logic [IDX_BITS-1:0]   raddr;
  logic [LEN_BITS:0]     rem_sh, rem_sub;
  logic                  full, last_of_pass;

  // clamped end and window bounds of the current bin
  always_comb begin
    n_m1   = cnt_q - CNT_BITS'(1);
    e_clip = (CNT_BITS'(re_q) > n_m1) ? n_m1[IDX_BITS-1:0] : re_q;
    lo_raw = {1'b0, idx_q} - {1'b0, rl_q};
    hi_raw = {1'b0, idx_q} + {1'b0, rr_q};
    lo     = (lo_raw[IDX_BITS] || (lo_raw[IDX_BITS-1:0] < rs_q)) ? rs_q
                                                                 : lo_raw[IDX_BITS-1:0];
    hi     = (hi_raw > {1'b0, e_clip}) ? e_clip : hi_raw[IDX_BITS-1:0];
    full   = (cnt_q == CNT_BITS'(DEPTH));
    last_of_pass = (CNT_BITS'(idx_q) == n_m1);
    raddr  = cmd_i.raw_rd ? idx_q : ptr_q;
    rem_sh  = {rem_q, quo_q[DIVD_BITS-1]};
    rem_sub = rem_sh - {1'b0, len_q};
  end

  assign stat_o.in_range = (idx_q >= rs_q) && (idx_q <= e_clip);
  assign stat_o.at_hi    = (ptr_q == hi_q);
  assign stat_o.div_done = (step_q == STEP_BITS'(DIVD_BITS - 1));
  assign stat_o.out_acc  = out_valid_q && out_ready_i;
  assign stat_o.out_last = out_q.last_result;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // bin store
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && !full) begin
      mem_q[cnt_q[IDX_BITS-1:0]] <= in_data_i.bin_value;
    end
    if (cmd_i.sum_rd || cmd_i.raw_rd) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rl_q        <= CFG_BITS'(1);
      rr_q        <= CFG_BITS'(1);
      rs_q        <= '0;
      re_q        <= CFG_BITS'(63);
      cnt_q       <= '0;
      idx_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cwhs_reg_e'(cfg_addr_i))
          REG_RADIUS_LEFT:  rl_q <= cfg_data_i;
          REG_RADIUS_RIGHT: rr_q <= cfg_data_i;
          REG_RANGE_START:  rs_q <= cfg_data_i;
          REG_RANGE_END:    re_q <= cfg_data_i;
          default:          rl_q <= rl_q;
        endcase
      end
      if (cmd_i.load && !full) begin
        cnt_q <= cnt_q + CNT_BITS'(1);
      end else if (cmd_i.pass_done) begin
        cnt_q <= '0;
      end
      if (cmd_i.start) begin
        idx_q <= '0;
      end else if (cmd_i.next_bin) begin
        idx_q <= idx_q + IDX_BITS'(1);
      end
      rd_vld_q <= cmd_i.sum_rd;
      if (cmd_i.out_mean || cmd_i.out_raw) begin
        out_valid_q <= 1'b1;
      end else if (stat_o.out_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // window sum and restoring divider
  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      ptr_q <= lo;
      hi_q  <= hi;
      len_q <= LEN_BITS'({1'b0, hi} - {1'b0, lo}) + LEN_BITS'(1);
      acc_q <= '0;
    end else begin
      if (cmd_i.sum_rd) begin
        ptr_q <= ptr_q + IDX_BITS'(1);
      end
      if (rd_vld_q) begin
        acc_q <= acc_q + SUM_BITS'(rdata_q);
      end
    end
    if (cmd_i.div_load) begin
      quo_q  <= {acc_q, {FRAC_BITS{1'b0}}};
      rem_q  <= '0;
      step_q <= '0;
    end else if (cmd_i.div_step) begin
      step_q <= step_q + STEP_BITS'(1);
      if (!rem_sub[LEN_BITS]) begin
        rem_q <= rem_sub[LEN_BITS-1:0];
        quo_q <= {quo_q[DIVD_BITS-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[LEN_BITS-1:0];
        quo_q <= {quo_q[DIVD_BITS-2:0], 1'b0};
      end
    end
    if (cmd_i.out_mean || cmd_i.out_raw) begin
      out_q.bin_index      <= idx_q;
      out_q.last_result    <= last_of_pass;
      out_q.smoothed_value <= cmd_i.out_mean ? quo_q[OUT_BITS-1:0]
                                             : {rdata_q, {FRAC_BITS{1'b0}}};
    end
  end

endmodule

FILE: hw/rtl/clipped_window_histogram_smoother_top.sv
// Histogram box-filter smoother. While idle, bins load one word per cycle into a 64-entry
// store (words past 64 are dropped); the word marked last_bin starts the output pass, which
// emits every loaded bin in index order and then returns to loading. A bin inside
// range_start..range_end (end clamped to the last loaded bin) becomes floor(256 * sum / len)
// over its window clipped to that range; other bins leave as value * 256. On the pass a
// smoothed bin makes one store read per window bin, then runs a 46-step restoring divider,
// one quotient bit per cycle; a raw bin makes a single store read. Configuration writes are
// taken in any cycle and belong between passes.
`include "clipped_window_histogram_smoother_top_defines.svh"

module clipped_window_histogram_smoother_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  cwhs_pkg::cwhs_in_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output cwhs_pkg::cwhs_out_t             out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [cwhs_pkg::ADDR_BITS-1:0]  cfg_addr_i,
  input  logic [cwhs_pkg::CFG_BITS-1:0]   cfg_data_i
);
  import cwhs_pkg::*;

  cwhs_cmd_t  cmd;
  cwhs_stat_t stat;

  assign cfg_ready_o = 1'b1;

  cwhs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_data_i.last_bin),
    .stat_i     (stat),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  cwhs_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_ready_i),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  `CWHS_ASSERT(a_no_load_during_pass, !(in_ready_o && out_valid_o), "load open while word pending")
  `CWHS_ASSERT(a_pass_continues, out_valid_o && out_ready_i && !out_data_o.last_result |=> !in_ready_o, "pass ended early")
  `CWHS_ASSERT(a_pass_ends, out_valid_o && out_ready_i && out_data_o.last_result |=> in_ready_o && !out_valid_o, "no return to loading after last word")
  `CWHS_ASSERT_RST(a_reset_idle, !rst_ni |=> !out_valid_o || !$past(rst_ni), "result word after reset")

endmodule
